// File: src/progressive_shift_cipher_core_defines.svh
// Assertion macros shared by the cipher core.
`ifndef PROGRESSIVE_SHIFT_CIPHER_CORE_DEFINES_SVH
`define PROGRESSIVE_SHIFT_CIPHER_CORE_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define PSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/psc_pkg.sv
`timescale 1ns / 1ps

package psc_pkg;

  typedef logic [7:0] char_t;
  typedef logic [4:0] lshift_t;
  typedef logic [3:0] dshift_t;

  typedef enum logic [1:0] {
    REG_BASE_SHIFT   = 2'd0,
    REG_SHIFT_STEP   = 2'd1,
    REG_ENCRYPT_MODE = 2'd2
  } reg_idx_t;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam char_t UPPER_FIRST = 8'd65;
  localparam char_t UPPER_LAST  = 8'd90;
  localparam char_t LOWER_FIRST = 8'd97;
  localparam char_t LOWER_LAST  = 8'd122;
  localparam char_t DIGIT_FIRST = 8'd48;
  localparam char_t DIGIT_LAST  = 8'd57;

  localparam logic [5:0] LETTER_SPAN = 6'd26;
  localparam logic [5:0] DIGIT_SPAN  = 6'd10;

  localparam char_t BASE_SHIFT_RST = 8'd3;
  localparam char_t SHIFT_STEP_RST = 8'd0;

  // Remainder by 26 through a reciprocal multiply and one correction step.
  function automatic lshift_t mod26(input char_t v);
    logic [15:0] prod;
    logic [3:0]  q;
    logic [7:0]  rem;
    prod = 16'(v) * 16'd158;
    q    = prod[15:12];
    rem  = v - 8'(q * 8'd26);
    if (rem >= 8'(LETTER_SPAN)) begin
      rem = rem - 8'(LETTER_SPAN);
    end
    return lshift_t'(rem);
  endfunction

  // Remainder by 10 through a reciprocal multiply and one correction step.
  function automatic dshift_t mod10(input char_t v);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  rem;
    prod = 16'(v) * 16'd205;
    q    = prod[15:11];
    rem  = v - 8'(q * 8'd10);
    if (rem >= 8'(DIGIT_SPAN)) begin
      rem = rem - 8'(DIGIT_SPAN);
    end
    return dshift_t'(rem);
  endfunction

  // Rotates a character within the range that starts at first and spans span codes.
  function automatic char_t rotate(input char_t c, input char_t first,
                                   input logic [5:0] span, input lshift_t s,
                                   input logic enc);
    logic [5:0] off;
    logic [5:0] sum;
    off = 6'(c - first);
    if (enc) begin
      sum = off + 6'(s);
    end else begin
      sum = off + span - 6'(s);
    end
    if (sum >= span) begin
      sum = sum - span;
    end
    return first + char_t'(sum);
  endfunction

endpackage

// File: src/progressive_shift_cipher_core.sv
// A word accepted at a rising edge is registered into out_char and appears after that edge.
// Throughput: one word per cycle while in_stall is low; the single output register frees itself when it is taken.
// The running letter and digit shifts are updated in the same cycle a word is accepted.
// Reset (synchronous, rst_n low) sets base_shift 3, shift_step 0, decrypt mode,
// both running shifts to 3 and clears the output valid flag.
`timescale 1ns / 1ps
`include "progressive_shift_cipher_core_defines.svh"

module progressive_shift_cipher_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_char,
  input  logic                              in_line_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_char,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [psc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [psc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [psc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  psc_pkg::char_t   base_shift_r;
  psc_pkg::char_t   shift_step_r;
  logic             encrypt_mode_r;
  psc_pkg::lshift_t base_m26_r;
  psc_pkg::dshift_t base_m10_r;
  psc_pkg::lshift_t step_m26_r;
  psc_pkg::dshift_t step_m10_r;
  psc_pkg::lshift_t letter_shift_r, letter_shift_nxt;
  psc_pkg::dshift_t digit_shift_r, digit_shift_nxt;
  logic             out_valid_r, out_valid_nxt;
  psc_pkg::char_t   out_char_r, out_char_nxt;

  psc_pkg::reg_idx_t cfg_idx;
  psc_pkg::char_t    wr_byte;
  logic              cfg_wr;
  logic              in_acc;
  logic              is_upper, is_lower, is_digit, is_alnum;
  psc_pkg::lshift_t  eff_l;
  psc_pkg::dshift_t  eff_d;
  logic [5:0]        l_sum;
  logic [4:0]        d_sum;

  assign pready   = 1'b1;
  assign cfg_idx  = psc_pkg::reg_idx_t'(paddr[psc_pkg::CFG_ADDR_W-1:2]);
  assign wr_byte  = pwdata[7:0];
  assign cfg_wr   = psel && penable && pwrite;

  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;

  always_comb begin
    case (cfg_idx)
      psc_pkg::REG_BASE_SHIFT:   prdata = psc_pkg::CFG_DATA_W'(base_shift_r);
      psc_pkg::REG_SHIFT_STEP:   prdata = psc_pkg::CFG_DATA_W'(shift_step_r);
      psc_pkg::REG_ENCRYPT_MODE: prdata = psc_pkg::CFG_DATA_W'(encrypt_mode_r);
      default:                   prdata = '0;
    endcase
  end

  assign is_upper = (in_char >= psc_pkg::UPPER_FIRST) && (in_char <= psc_pkg::UPPER_LAST);
  assign is_lower = (in_char >= psc_pkg::LOWER_FIRST) && (in_char <= psc_pkg::LOWER_LAST);
  assign is_digit = (in_char >= psc_pkg::DIGIT_FIRST) && (in_char <= psc_pkg::DIGIT_LAST);
  assign is_alnum = is_upper || is_lower || is_digit;

  // A line start restarts the position count before this word is rotated.
  assign eff_l = in_line_start ? base_m26_r : letter_shift_r;
  assign eff_d = in_line_start ? base_m10_r : digit_shift_r;

  always_comb begin
    if (is_upper) begin
      out_char_nxt = psc_pkg::rotate(in_char, psc_pkg::UPPER_FIRST, psc_pkg::LETTER_SPAN,
                                     eff_l, encrypt_mode_r);
    end else if (is_lower) begin
      out_char_nxt = psc_pkg::rotate(in_char, psc_pkg::LOWER_FIRST, psc_pkg::LETTER_SPAN,
                                     eff_l, encrypt_mode_r);
    end else if (is_digit) begin
      out_char_nxt = psc_pkg::rotate(in_char, psc_pkg::DIGIT_FIRST, psc_pkg::DIGIT_SPAN,
                                     psc_pkg::lshift_t'(eff_d), encrypt_mode_r);
    end else begin
      out_char_nxt = in_char;
    end
  end

  always_comb begin
    l_sum = 6'(eff_l) + 6'(step_m26_r);
    if (l_sum >= psc_pkg::LETTER_SPAN) begin
      l_sum = l_sum - psc_pkg::LETTER_SPAN;
    end
    d_sum = 5'(eff_d) + 5'(step_m10_r);
    if (d_sum >= 5'(psc_pkg::DIGIT_SPAN)) begin
      d_sum = d_sum - 5'(psc_pkg::DIGIT_SPAN);
    end
  end

  // Writes to base_shift or shift_step take priority over the running state update.
  always_comb begin
    letter_shift_nxt = letter_shift_r;
    digit_shift_nxt  = digit_shift_r;
    if (cfg_wr && (cfg_idx == psc_pkg::REG_BASE_SHIFT)) begin
      letter_shift_nxt = psc_pkg::mod26(wr_byte);
      digit_shift_nxt  = psc_pkg::mod10(wr_byte);
    end else if (cfg_wr && (cfg_idx == psc_pkg::REG_SHIFT_STEP)) begin
      letter_shift_nxt = base_m26_r;
      digit_shift_nxt  = base_m10_r;
    end else if (in_acc) begin
      if (is_alnum) begin
        letter_shift_nxt = psc_pkg::lshift_t'(l_sum);
        digit_shift_nxt  = psc_pkg::dshift_t'(d_sum);
      end else begin
        letter_shift_nxt = eff_l;
        digit_shift_nxt  = eff_d;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_shift_r   <= psc_pkg::BASE_SHIFT_RST;
      shift_step_r   <= psc_pkg::SHIFT_STEP_RST;
      encrypt_mode_r <= 1'b0;
      base_m26_r     <= psc_pkg::mod26(psc_pkg::BASE_SHIFT_RST);
      base_m10_r     <= psc_pkg::mod10(psc_pkg::BASE_SHIFT_RST);
      step_m26_r     <= psc_pkg::mod26(psc_pkg::SHIFT_STEP_RST);
      step_m10_r     <= psc_pkg::mod10(psc_pkg::SHIFT_STEP_RST);
    end else if (cfg_wr) begin
      case (cfg_idx)
        psc_pkg::REG_BASE_SHIFT: begin
          base_shift_r <= wr_byte;
          base_m26_r   <= psc_pkg::mod26(wr_byte);
          base_m10_r   <= psc_pkg::mod10(wr_byte);
        end
        psc_pkg::REG_SHIFT_STEP: begin
          shift_step_r <= wr_byte;
          step_m26_r   <= psc_pkg::mod26(wr_byte);
          step_m10_r   <= psc_pkg::mod10(wr_byte);
        end
        psc_pkg::REG_ENCRYPT_MODE: begin
          encrypt_mode_r <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letter_shift_r <= psc_pkg::mod26(psc_pkg::BASE_SHIFT_RST);
      digit_shift_r  <= psc_pkg::mod10(psc_pkg::BASE_SHIFT_RST);
      out_valid_r    <= 1'b0;
    end else begin
      letter_shift_r <= letter_shift_nxt;
      digit_shift_r  <= digit_shift_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_char_r <= out_char_nxt;
    end
  end

  `PSC_ASSERT_NEXT(a_accept_gives_word, clk, rst_n, in_acc, out_valid_r,
    "accepted word did not reach the output register")
  `PSC_ASSERT_NOW(a_shift_in_range, clk, rst_n, 1'b1,
    (letter_shift_r < 5'(psc_pkg::LETTER_SPAN)) && (digit_shift_r < 4'(psc_pkg::DIGIT_SPAN)),
    "running shift left its modular range")
  `PSC_ASSERT_NEXT(a_other_passes, clk, rst_n, in_acc && !is_alnum,
    out_char_r == $past(in_char), "non-alphanumeric word was altered")
  `PSC_ASSERT_NEXT(a_other_holds_shift, clk, rst_n,
    in_acc && !is_alnum && !in_line_start && !cfg_wr,
    $stable(letter_shift_r) && $stable(digit_shift_r),
    "non-alphanumeric word advanced the position count")

endmodule
